// File: sv/sacl_pkg.sv
`timescale 1ns / 1ps

package sacl_pkg;

	localparam int STAMP_W = 32;
	localparam int USE_W   = 16;
	localparam int LAT_W   = 16;
	localparam int TOTAL_W = 32;
	localparam int CFG_IDX_W = 4;

	localparam logic [USE_W-1:0] USE_MAX = '1;

	typedef logic [STAMP_W-1:0] stamp_t;
	typedef logic [USE_W-1:0]   use_t;
	typedef logic [LAT_W-1:0]   lat_t;
	typedef logic [TOTAL_W-1:0] total_t;

	typedef enum logic [1:0] {
		OUT_HIT   = 2'd0,
		OUT_FILL  = 2'd1,
		OUT_EVICT = 2'd2
	} outcome_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LFU_MODE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIT_LAT   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MISS_LAT  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EVICT_LAT = 4'd3;

endpackage

// File: sv/sacl_victim_sel.sv
`timescale 1ns / 1ps

module sacl_victim_sel #(
	parameter int WAYS  = 4,
	parameter int WAY_W = 2
) (
	input  logic                                   lfu_mode,
	input  logic [WAYS-1:0][sacl_pkg::STAMP_W-1:0] stamps,
	input  logic [WAYS-1:0][sacl_pkg::USE_W-1:0]   counts,
	output logic [WAY_W-1:0]                       victim_way
);
	import sacl_pkg::*;

	localparam int KEY_W = USE_W + STAMP_W;
	localparam int LVLS  = WAY_W;
	localparam int NP    = 1 << LVLS;

	logic [KEY_W-1:0] key_l [LVLS+1][NP];
	logic [WAY_W-1:0] idx_l [LVLS+1][NP];

	// Min tree; on equal keys the lower way wins, matching a first-to-last scan
	// with strict compare. Padding leaves carry the largest key and never win.
	always_comb begin
		for (int l = 0; l <= LVLS; l++) begin
			for (int i = 0; i < NP; i++) begin
				key_l[l][i] = '1;
				idx_l[l][i] = '0;
			end
		end
		for (int i = 0; i < WAYS; i++) begin
			key_l[0][i] = lfu_mode ? {counts[i], stamps[i]} : {{USE_W{1'b0}}, stamps[i]};
			idx_l[0][i] = WAY_W'(i);
		end
		for (int l = 0; l < LVLS; l++) begin
			for (int i = 0; i < (NP >> (l + 1)); i++) begin
				if (key_l[l][2*i+1] < key_l[l][2*i]) begin
					key_l[l+1][i] = key_l[l][2*i+1];
					idx_l[l+1][i] = idx_l[l][2*i+1];
				end else begin
					key_l[l+1][i] = key_l[l][2*i];
					idx_l[l+1][i] = idx_l[l][2*i];
				end
			end
		end
	end

	assign victim_way = idx_l[LVLS][0];

endmodule

// File: sv/set_assoc_cache_tag_lfu_lru.sv
`timescale 1ns / 1ps

// Tag store of a set-associative cache with LRU or LFU replacement.
// Access channel: pulse start with access_address; a transaction is taken at
// any edge where start is high and busy is low. busy stays low, so one access
// can be taken every cycle.
// Result channel: done is high for exactly one cycle per access, driven from
// done_q, which follows the stage-1 valid vld_s1, with outcome, victim/filled
// block addresses, latency and the running totals. The receiver cannot stall;
// results must be sampled in the done cycle.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// register (0 policy, 1 hit latency, 2 miss latency, 3 eviction latency),
// cfg_data holds the value. cfg_ready is always high. Write only while idle.
// Throughput is one access per cycle: each set's ways live in one row of a
// synchronous memory read at the accept edge; a back-to-back access to the
// same set takes the row being written back through a forwarding register.
// Reset clears all line valid bits, set clocks and totals and loads the
// register defaults (LFU, latencies 1/100/100); no clearing pass is needed.

module set_assoc_cache_tag_lfu_lru #(
	parameter int OFFSET_BITS  = 6,
	parameter int INDEX_BITS   = 6,
	parameter int WAYS         = 4,
	parameter int ADDRESS_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [ADDRESS_BITS-1:0]          access_address,
	output logic                             done,
	output logic [1:0]                       outcome,
	output logic [ADDRESS_BITS-1:0]          victim_block,
	output logic [ADDRESS_BITS-1:0]          filled_block,
	output logic [sacl_pkg::LAT_W-1:0]       latency,
	output logic [sacl_pkg::TOTAL_W-1:0]     hits_so_far,
	output logic [sacl_pkg::TOTAL_W-1:0]     misses_so_far,
	output logic [sacl_pkg::TOTAL_W-1:0]     evictions_so_far,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sacl_pkg::LAT_W-1:0]       cfg_data
);
	import sacl_pkg::*;

	localparam int SET_COUNT = 1 << INDEX_BITS;
	localparam int SET_W     = (INDEX_BITS > 0) ? INDEX_BITS : 1;
	localparam int TAG_W     = ADDRESS_BITS - INDEX_BITS - OFFSET_BITS;
	localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int BLK_SH    = INDEX_BITS + OFFSET_BITS;

	localparam logic [ADDRESS_BITS-1:0] SET_LOW_MASK = ADDRESS_BITS'(SET_COUNT - 1);
	localparam logic [ADDRESS_BITS-1:0] OFF_MASK     = ADDRESS_BITS'((64'd1 << OFFSET_BITS) - 1);
	localparam logic [ADDRESS_BITS-1:0] BLK_MASK     = ADDRESS_BITS'((64'd1 << BLK_SH) - 1);
	localparam logic [ADDRESS_BITS-1:0] SET_FIELD    = BLK_MASK & ~OFF_MASK;

	// set row memories
	logic [WAYS-1:0][TAG_W-1:0] tag_mem   [SET_COUNT];
	logic [WAYS-1:0][STAMP_W-1:0] stamp_mem [SET_COUNT];
	logic [WAYS-1:0][USE_W-1:0] count_mem [SET_COUNT];
	stamp_t                     clock_mem [SET_COUNT];

	logic [WAYS-1:0] valid_q   [SET_COUNT];
	logic            touched_q [SET_COUNT];

	// configuration
	logic lfu_q;
	lat_t hit_lat_q, miss_lat_q, evict_lat_q;

	// stage 1
	logic                       vld_s1;
	logic [ADDRESS_BITS-1:0]    addr_s1;
	logic [WAYS-1:0][TAG_W-1:0] tag_rd_s1;
	logic [WAYS-1:0][STAMP_W-1:0] stamp_rd_s1;
	logic [WAYS-1:0][USE_W-1:0] count_rd_s1;
	stamp_t                     clock_rd_s1;
	logic                       fwd_s1;
	logic [WAYS-1:0][TAG_W-1:0] tag_fwd_s1;
	logic [WAYS-1:0][STAMP_W-1:0] stamp_fwd_s1;
	logic [WAYS-1:0][USE_W-1:0] count_fwd_s1;
	stamp_t                     clock_fwd_s1;

	// results
	logic                    done_q;
	outcome_t                outcome_q;
	logic [ADDRESS_BITS-1:0] victim_q, filled_q;
	lat_t                    lat_q;
	total_t                  hit_total_q, miss_total_q, evict_total_q;

	// combinational
	logic                       accept;
	logic [SET_W-1:0]           in_set;
	logic [SET_W-1:0]           set_s1;
	logic [TAG_W-1:0]           tag_s1;
	logic [WAYS-1:0][TAG_W-1:0] tags;
	logic [WAYS-1:0][STAMP_W-1:0] stamps;
	logic [WAYS-1:0][USE_W-1:0] counts;
	stamp_t                     clock_cur;
	logic [WAYS-1:0]            valid_cur;
	logic                       hit;
	logic [WAY_W-1:0]           hit_way;
	logic                       any_free;
	logic [WAY_W-1:0]           free_way;
	logic [WAY_W-1:0]           victim_way;
	logic [WAY_W-1:0]           use_way;
	logic [WAYS-1:0][TAG_W-1:0] tag_wr;
	logic [WAYS-1:0][STAMP_W-1:0] stamp_wr;
	logic [WAYS-1:0][USE_W-1:0] count_wr;
	stamp_t                     clock_wr;
	outcome_t                   outcome_nx;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign in_set    = SET_W'((access_address >> OFFSET_BITS) & SET_LOW_MASK);
	assign set_s1    = SET_W'((addr_s1 >> OFFSET_BITS) & SET_LOW_MASK);
	assign tag_s1    = TAG_W'(addr_s1 >> BLK_SH);

	assign tags      = fwd_s1 ? tag_fwd_s1   : tag_rd_s1;
	assign stamps    = fwd_s1 ? stamp_fwd_s1 : stamp_rd_s1;
	assign counts    = fwd_s1 ? count_fwd_s1 : count_rd_s1;
	assign clock_cur = fwd_s1 ? clock_fwd_s1 : (touched_q[set_s1] ? clock_rd_s1 : '0);
	assign valid_cur = valid_q[set_s1];

	always_comb begin
		hit      = 1'b0;
		hit_way  = '0;
		any_free = 1'b0;
		free_way = '0;
		// scan downwards so the lowest matching way is left standing
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (valid_cur[w] && tags[w] == tag_s1) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!valid_cur[w]) begin
				any_free = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	sacl_victim_sel #(
		.WAYS  (WAYS),
		.WAY_W (WAY_W)
	) u_victim_sel (
		.lfu_mode   (lfu_q),
		.stamps     (stamps),
		.counts     (counts),
		.victim_way (victim_way)
	);

	assign use_way = hit ? hit_way : (any_free ? free_way : victim_way);

	always_comb begin
		tag_wr   = tags;
		stamp_wr = stamps;
		count_wr = counts;
		clock_wr = clock_cur + ((hit && lfu_q) ? stamp_t'(1) : stamp_t'(2));
		if (hit) begin
			if (!lfu_q) begin
				stamp_wr[hit_way] = clock_wr;
			end else if (counts[hit_way] != USE_MAX) begin
				count_wr[hit_way] = counts[hit_way] + use_t'(1);
			end
		end else begin
			tag_wr[use_way]   = tag_s1;
			stamp_wr[use_way] = clock_wr;
			count_wr[use_way] = use_t'(1);
		end
	end

	always_comb begin
		if (hit) begin
			outcome_nx = OUT_HIT;
		end else if (any_free) begin
			outcome_nx = OUT_FILL;
		end else begin
			outcome_nx = OUT_EVICT;
		end
	end

	// memory: read at the accept edge, write back the updated row from stage 1
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			tag_mem[set_s1]   <= tag_wr;
			stamp_mem[set_s1] <= stamp_wr;
			count_mem[set_s1] <= count_wr;
			clock_mem[set_s1] <= clock_wr;
		end
		if (accept) begin
			tag_rd_s1    <= tag_mem[in_set];
			stamp_rd_s1  <= stamp_mem[in_set];
			count_rd_s1  <= count_mem[in_set];
			clock_rd_s1  <= clock_mem[in_set];
			addr_s1      <= access_address;
			tag_fwd_s1   <= tag_wr;
			stamp_fwd_s1 <= stamp_wr;
			count_fwd_s1 <= count_wr;
			clock_fwd_s1 <= clock_wr;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			outcome_q <= outcome_nx;
			filled_q  <= hit ? '0 : (addr_s1 & ~OFF_MASK);
			victim_q  <= (outcome_nx == OUT_EVICT)
				? ((ADDRESS_BITS'(tags[victim_way]) << BLK_SH) | (addr_s1 & SET_FIELD))
				: '0;
			case (outcome_nx)
				OUT_HIT:  lat_q <= hit_lat_q;
				OUT_FILL: lat_q <= miss_lat_q;
				default:  lat_q <= evict_lat_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			fwd_s1        <= 1'b0;
			done_q        <= 1'b0;
			hit_total_q   <= '0;
			miss_total_q  <= '0;
			evict_total_q <= '0;
			for (int s = 0; s < SET_COUNT; s++) begin
				valid_q[s]   <= '0;
				touched_q[s] <= 1'b0;
			end
		end else begin
			vld_s1 <= accept;
			fwd_s1 <= accept && vld_s1 && (in_set == set_s1);
			done_q <= vld_s1;
			if (vld_s1) begin
				touched_q[set_s1] <= 1'b1;
				if (hit) begin
					hit_total_q <= hit_total_q + total_t'(1);
				end else begin
					valid_q[set_s1][use_way] <= 1'b1;
					miss_total_q <= miss_total_q + total_t'(1);
					if (!any_free) begin
						evict_total_q <= evict_total_q + total_t'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfu_q       <= 1'b1;
			hit_lat_q   <= lat_t'(1);
			miss_lat_q  <= lat_t'(100);
			evict_lat_q <= lat_t'(100);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LFU_MODE:  lfu_q       <= cfg_data[0];
				REG_HIT_LAT:   hit_lat_q   <= cfg_data;
				REG_MISS_LAT:  miss_lat_q  <= cfg_data;
				REG_EVICT_LAT: evict_lat_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign done             = done_q;
	assign outcome          = outcome_q;
	assign victim_block     = victim_q;
	assign filled_block     = filled_q;
	assign latency          = lat_q;
	assign hits_so_far      = hit_total_q;
	assign misses_so_far    = miss_total_q;
	assign evictions_so_far = evict_total_q;

	// every taken transaction passes through vld_s1 and then raises done via done_q
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> done)
		else $error("accepted access produced no result");

	a_hit_no_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(done && outcome == OUT_HIT) |-> (victim_block == '0 && filled_block == '0))
		else $error("hit reported block addresses");

	a_victim_only_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && outcome != OUT_EVICT) |-> victim_block == '0)
		else $error("victim address without eviction");

	a_set_has_line: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> valid_q[$past(set_s1)] != '0)
		else $error("accessed set left with no valid line");

	a_miss_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !hit) |=> misses_so_far == $past(miss_total_q) + total_t'(1))
		else $error("miss total did not advance");

endmodule
